@@ src/spisc_pkg.sv @@
`default_nettype none

package spisc_pkg;

  localparam int unsigned DATA_BYTES = 28;
  localparam int unsigned DATA_IDX_W = $clog2(DATA_BYTES);
  localparam int unsigned BYTE_POS_W = 6;

  localparam logic [31:0] MAGIC_WORD = 32'h3146_4745;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  localparam logic [1:0] FUNC_SELECT   = 2'd0;
  localparam logic [1:0] FUNC_REQUEST  = 2'd1;
  localparam logic [1:0] FUNC_DESELECT = 2'd2;

  typedef enum logic [1:0] {
    OP_SELECT,
    OP_REQUEST,
    OP_DESELECT
  } op_e;

  typedef struct packed {
    op_e                        op;
    logic [DATA_BYTES-1:0][7:0] bytes;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/spisc_fifo.sv @@
`default_nettype none

module spisc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/spisc_front.sv @@
`default_nettype none

module spisc_front (
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [31:0]        update_tick_i,
  input  wire logic signed [30:0] latitude_e7_i,
  input  wire logic signed [31:0] longitude_e7_i,
  input  wire logic signed [31:0] altitude_cm_i,
  input  wire logic [15:0]        hdop_centi_i,
  input  wire logic [15:0]        residual_cm_i,
  input  wire logic [7:0]         fix_status_i,
  input  wire logic [7:0]         used_mask_i,
  input  wire logic [7:0]         rejected_mask_i,
  input  wire logic               fix_valid_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output spisc_pkg::cmd_t         cmd_o
);

  import spisc_pkg::*;

  logic known;

  assign in_ready_o = !full_i;

  always_comb begin
    known       = 1'b1;
    cmd_o.op    = OP_REQUEST;
    cmd_o.bytes = {7'b0, fix_valid_i, rejected_mask_i, used_mask_i, fix_status_i,
                   residual_cm_i, hdop_centi_i, altitude_cm_i, longitude_e7_i,
                   latitude_e7_i[30], latitude_e7_i, update_tick_i, MAGIC_WORD};
    unique case (func_i)
      FUNC_SELECT:   cmd_o.op = OP_SELECT;
      FUNC_REQUEST:  cmd_o.op = OP_REQUEST;
      FUNC_DESELECT: cmd_o.op = OP_DESELECT;
      default:       known = 1'b0;
    endcase
  end

  assign push_o = in_valid_i && in_ready_o && known;

endmodule

`default_nettype wire

@@ src/spisc_back.sv @@
`default_nettype none

module spisc_back #(
  parameter int unsigned PACKET_BYTES = 30
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cmd_valid_i,
  input  wire spisc_pkg::cmd_t                     cmd_i,
  output logic                                     cmd_pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [7:0]                               tx_byte_o,
  output logic [spisc_pkg::BYTE_POS_W-1:0]         byte_position_o,
  output logic                                     last_byte_o
);

  import spisc_pkg::*;

  localparam int unsigned POS_W     = $clog2(PACKET_BYTES + 1);
  localparam int unsigned CNT_W     = $clog2(PACKET_BYTES - 1);
  localparam int unsigned CRC_BYTES = PACKET_BYTES - 2;

  logic                       sel_q, sel_d;
  logic [POS_W-1:0]           pos_q, pos_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [15:0]                crc_q, crc_d;
  logic [DATA_BYTES-1:0][7:0] data_q, data_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 tx_byte_q, tx_byte_d;
  logic [BYTE_POS_W-1:0]      pos_out_q, pos_out_d;
  logic                       last_q, last_d;

  logic       crc_done;
  logic [7:0] crc_in;
  logic       avail;
  logic       stall;
  logic       out_free;
  logic [7:0] cur_byte;

  assign crc_done = (cnt_q == CNT_W'(CRC_BYTES));
  assign crc_in   = (cnt_q < CNT_W'(DATA_BYTES)) ? data_q[cnt_q[DATA_IDX_W-1:0]] : 8'h00;
  assign avail    = sel_q && (pos_q < POS_W'(PACKET_BYTES));
  assign stall    = (cmd_i.op == OP_REQUEST) && avail &&
                    (pos_q >= POS_W'(CRC_BYTES)) && !crc_done;
  assign out_free = !out_valid_q || out_ready_i;
  assign cmd_pop_o = cmd_valid_i && !stall && ((cmd_i.op == OP_DESELECT) || out_free);

  always_comb begin
    if (pos_q < POS_W'(DATA_BYTES)) begin
      cur_byte = data_q[pos_q[DATA_IDX_W-1:0]];
    end else if (pos_q == POS_W'(CRC_BYTES)) begin
      cur_byte = crc_q[7:0];
    end else if (pos_q == POS_W'(PACKET_BYTES - 1)) begin
      cur_byte = crc_q[15:8];
    end else begin
      cur_byte = 8'h00;
    end
  end

  always_comb begin
    sel_d       = sel_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    data_d      = data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tx_byte_d   = tx_byte_q;
    pos_out_d   = pos_out_q;
    last_d      = last_q;

    if (!crc_done) begin
      crc_d = crc_byte(crc_q, crc_in);
      cnt_d = cnt_q + 1'b1;
    end

    if (cmd_pop_o) begin
      unique case (cmd_i.op)
        OP_SELECT: begin
          sel_d       = 1'b1;
          pos_d       = POS_W'(1);
          data_d      = cmd_i.bytes;
          crc_d       = CRC_INIT;
          cnt_d       = '0;
          out_valid_d = 1'b1;
          tx_byte_d   = MAGIC_WORD[7:0];
          pos_out_d   = '0;
          last_d      = 1'b0;
        end
        OP_REQUEST: begin
          out_valid_d = 1'b1;
          if (avail) begin
            tx_byte_d = cur_byte;
            pos_out_d = BYTE_POS_W'(pos_q);
            last_d    = (pos_q == POS_W'(PACKET_BYTES - 1));
            pos_d     = pos_q + 1'b1;
          end else begin
            tx_byte_d = 8'h00;
            pos_out_d = BYTE_POS_W'(PACKET_BYTES);
            last_d    = 1'b0;
          end
        end
        OP_DESELECT: begin
          sel_d = 1'b0;
          pos_d = '0;
        end
        default: begin
          sel_d = sel_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      pos_q       <= '0;
      cnt_q       <= CNT_W'(CRC_BYTES);
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q     <= crc_d;
    data_q    <= data_d;
    tx_byte_q <= tx_byte_d;
    pos_out_q <= pos_out_d;
    last_q    <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign tx_byte_o       = tx_byte_q;
  assign byte_position_o = pos_out_q;
  assign last_byte_o     = last_q;

`ifndef SYNTHESIS
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> byte_position_o == BYTE_POS_W'(PACKET_BYTES - 1))
    else $error("last byte flagged away from final position");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(PACKET_BYTES))
    else $error("send position beyond packet end");

  a_crc_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CRC_BYTES))
    else $error("crc byte count overran");

  a_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o && cmd_i.op == OP_SELECT |=> sel_q && pos_q == POS_W'(1) && cnt_q == '0)
    else $error("select did not restart packet");

  a_crc_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && sel_q && pos_out_q >= BYTE_POS_W'(CRC_BYTES) &&
    pos_out_q < BYTE_POS_W'(PACKET_BYTES) |-> crc_done)
    else $error("crc byte sent before crc finished");
`endif

endmodule

`default_nettype wire

@@ src/spi_slave_crc_packet_server_unit.sv @@
`default_nettype none

// SPI slave transmit side for a position report. A select beat (func 0) snapshots the
// position fields, rebuilds the PACKET_BYTES-byte packet (magic word, tick, latitude,
// longitude, altitude, HDOP, residual, status, masks, fix flag, zero padding, CRC-16
// CCITT-FALSE little-endian in the last two bytes) and returns byte 0. Each byte request
// (func 1) returns the next byte, or 0x00 at position PACKET_BYTES when not selected or
// past the end; deselect (func 2) returns nothing; func 3 is dropped. One input beat and
// one output beat per cycle, unless the queue is full, the output is held by out_ready_i
// or a CRC byte must wait. A two-entry queue separates the decoder from the sender: each
// beat is written into the queue, and its result is then registered at the sender output.
// The CRC engine covers one packet byte per cycle once the select leaves the queue, so a
// request for a CRC byte waits in the queue until the CRC over the earlier bytes is done.
module spi_slave_crc_packet_server_unit #(
  parameter int unsigned PACKET_BYTES = 30
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [31:0]        update_tick_i,
  input  wire logic signed [30:0] latitude_e7_i,
  input  wire logic signed [31:0] longitude_e7_i,
  input  wire logic signed [31:0] altitude_cm_i,
  input  wire logic [15:0]        hdop_centi_i,
  input  wire logic [15:0]        residual_cm_i,
  input  wire logic [7:0]         fix_status_i,
  input  wire logic [7:0]         used_mask_i,
  input  wire logic [7:0]         rejected_mask_i,
  input  wire logic               fix_valid_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              tx_byte_o,
  output logic [5:0]              byte_position_o,
  output logic                    last_byte_o
);

  import spisc_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  spisc_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .update_tick_i   (update_tick_i),
    .latitude_e7_i   (latitude_e7_i),
    .longitude_e7_i  (longitude_e7_i),
    .altitude_cm_i   (altitude_cm_i),
    .hdop_centi_i    (hdop_centi_i),
    .residual_cm_i   (residual_cm_i),
    .fix_status_i    (fix_status_i),
    .used_mask_i     (used_mask_i),
    .rejected_mask_i (rejected_mask_i),
    .fix_valid_i     (fix_valid_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  spisc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .pop_data_o  (head_cmd)
  );

  spisc_back #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (head_valid),
    .cmd_i           (head_cmd),
    .cmd_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tx_byte_o       (tx_byte_o),
    .byte_position_o (byte_position_o),
    .last_byte_o     (last_byte_o)
  );

endmodule

`default_nettype wire
